FILE: design/deq_pkg.sv
// Shared types, constants and ring helpers for the double-ended queue.
package deq_pkg;

    localparam int CAPACITY = 1024;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int SUM_W    = IDX_W + 1;
    localparam int DATA_W   = 32;

    localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [2:0] CMD_POP_BACK   = 3'd3;
    localparam logic [2:0] CMD_QUERY      = 3'd4;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    localparam logic signed [DATA_W-1:0] NEG_ONE = -32'sd1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_HOLD
    } state_t;

    typedef struct packed {
        logic [2:0]               cmd;
        logic signed [DATA_W-1:0] push_value;
    } req_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] popped_value;
        logic [1:0]               status;
        logic [CNT_W-1:0]         occupancy;
        logic                     is_empty;
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] back_value;
    } rsp_item_t;

    // head + off with wrap; off is always below CAPACITY
    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] head,
                                                  input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(off);
        if (sum >= SUM_W'(CAPACITY)) begin
            sum = sum - SUM_W'(CAPACITY);
        end
        return sum[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] head);
        logic [IDX_W-1:0] res;
        if (head == '0) begin
            res = IDX_W'(CAPACITY - 1);
        end
        else begin
            res = head - IDX_W'(1);
        end
        return res;
    endfunction

endpackage

FILE: design/deq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/deq_out_stage.sv
// Output register stage for result items.
module deq_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  deq_pkg::rsp_item_t  load_item,
    output logic                free,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output deq_pkg::rsp_item_t  rsp
);

    logic               valid_reg;
    deq_pkg::rsp_item_t data_reg;

    assign free = !valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_item;
        end
    end

    assign rsp_valid = valid_reg;
    assign rsp       = data_reg;

endmodule

FILE: design/double_ended_queue.sv
// Double-ended queue of signed 32-bit values in a ring-buffer RAM, one result per command.
//
// Commands push or pop at either end, or only query; each accepted item yields one
// result with the popped value, status, occupancy, empty flag and the front and back
// values. Entries live in a 1024 x 32 RAM with a registered read; the head pointer,
// the count and copies of the front and back values sit in flops. Pushes,
// queries, failed commands and pops that leave at most one entry need no RAM read:
// an item can be taken every cycle while the output register is free. A pop that
// leaves two or more entries needs the new end value from the RAM, so it waits in
// S_READ for the read, during which req_ready is low. A finished result sits in an
// output register; while it waits the block still takes one more item and parks its
// result, then stalls until the output register frees up. A push into a full queue
// is dropped with a full status; a pop on an empty queue returns -1 with an empty
// status. No clearing pass is needed after reset: only written entries are ever read.
module double_ended_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  deq_pkg::req_item_t  req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output deq_pkg::rsp_item_t  rsp
);

    // Control and pointer state
    deq_pkg::state_t                    state_reg, state_next;
    logic [deq_pkg::IDX_W-1:0]          head_reg, head_next;
    logic [deq_pkg::CNT_W-1:0]          count_reg, count_next;
    logic signed [deq_pkg::DATA_W-1:0]  front_reg, front_next;
    logic signed [deq_pkg::DATA_W-1:0]  back_reg, back_next;
    // Parked result and which end the pending RAM read refills
    deq_pkg::rsp_item_t                 pend_reg, pend_next;
    logic                               rd_front_reg, rd_front_next;

    // RAM port
    logic                               mem_we;
    logic [deq_pkg::IDX_W-1:0]          mem_waddr;
    logic                               mem_re;
    logic [deq_pkg::IDX_W-1:0]          mem_raddr;
    logic [deq_pkg::DATA_W-1:0]         mem_rdata;

    // Output stage
    logic                               out_load;
    deq_pkg::rsp_item_t                 out_item;
    logic                               out_free;

    logic                               accept;
    logic                               is_empty_q;
    logic                               is_full_q;
    deq_pkg::rsp_item_t                 res;

    assign req_ready  = (state_reg == deq_pkg::S_IDLE);
    assign accept     = req_valid && req_ready;
    assign is_empty_q = (count_reg == '0);
    assign is_full_q  = (count_reg == deq_pkg::CNT_W'(deq_pkg::CAPACITY));

    deq_ram #(
        .WIDTH (deq_pkg::DATA_W),
        .DEPTH (deq_pkg::CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (req.push_value),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    deq_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .load_item (out_item),
        .free      (out_free),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= deq_pkg::S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // Cached end values are only meaningful while count is nonzero
    always_ff @(posedge clk)
    begin
        front_reg    <= front_next;
        back_reg     <= back_next;
        pend_reg     <= pend_next;
        rd_front_reg <= rd_front_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        front_next    = front_reg;
        back_next     = back_reg;
        pend_next     = pend_reg;
        rd_front_next = rd_front_reg;
        mem_we        = 1'b0;
        mem_waddr     = head_reg;
        mem_re        = 1'b0;
        mem_raddr     = head_reg;
        out_load      = 1'b0;
        out_item      = pend_reg;
        res           = pend_reg;

        unique case (state_reg)
            deq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    res.popped_value = deq_pkg::NEG_ONE;
                    res.status       = deq_pkg::STATUS_OK;
                    unique case (req.cmd)
                        deq_pkg::CMD_PUSH_FRONT:
                        begin
                            if (is_full_q)
                            begin
                                res.status = deq_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                head_next  = deq_pkg::ring_dec(head_reg);
                                mem_we     = 1'b1;
                                mem_waddr  = head_next;
                                count_next = count_reg + deq_pkg::CNT_W'(1);
                                front_next = req.push_value;
                                if (is_empty_q)
                                begin
                                    back_next = req.push_value;
                                end
                            end
                        end
                        deq_pkg::CMD_PUSH_BACK:
                        begin
                            if (is_full_q)
                            begin
                                res.status = deq_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = deq_pkg::ring_add(head_reg, count_reg);
                                count_next = count_reg + deq_pkg::CNT_W'(1);
                                back_next  = req.push_value;
                                if (is_empty_q)
                                begin
                                    front_next = req.push_value;
                                end
                            end
                        end
                        deq_pkg::CMD_POP_FRONT:
                        begin
                            if (is_empty_q)
                            begin
                                res.status = deq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                res.popped_value = front_reg;
                                head_next  = deq_pkg::ring_add(head_reg, deq_pkg::CNT_W'(1));
                                count_next = count_reg - deq_pkg::CNT_W'(1);
                                // one entry left: it is the old back
                                front_next = back_reg;
                                if (count_reg >= deq_pkg::CNT_W'(3))
                                begin
                                    mem_re        = 1'b1;
                                    mem_raddr     = head_next;
                                    rd_front_next = 1'b1;
                                end
                            end
                        end
                        deq_pkg::CMD_POP_BACK:
                        begin
                            if (is_empty_q)
                            begin
                                res.status = deq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                res.popped_value = back_reg;
                                count_next = count_reg - deq_pkg::CNT_W'(1);
                                back_next  = front_reg;
                                if (count_reg >= deq_pkg::CNT_W'(3))
                                begin
                                    mem_re        = 1'b1;
                                    mem_raddr     = deq_pkg::ring_add(head_reg,
                                                        count_reg - deq_pkg::CNT_W'(2));
                                    rd_front_next = 1'b0;
                                end
                            end
                        end
                        default:
                        begin
                            // query and unused codes change nothing
                        end
                    endcase

                    res.occupancy = count_next;
                    res.is_empty  = (count_next == '0);
                    if (count_next == '0)
                    begin
                        res.front_value = deq_pkg::NEG_ONE;
                        res.back_value  = deq_pkg::NEG_ONE;
                    end
                    else
                    begin
                        res.front_value = front_next;
                        res.back_value  = back_next;
                    end

                    if (mem_re)
                    begin
                        pend_next  = res;
                        state_next = deq_pkg::S_READ;
                    end
                    else if (out_free)
                    begin
                        out_load = 1'b1;
                        out_item = res;
                    end
                    else
                    begin
                        pend_next  = res;
                        state_next = deq_pkg::S_HOLD;
                    end
                end
            end
            deq_pkg::S_READ:
            begin
                // patch the refilled end from the RAM read
                if (rd_front_reg)
                begin
                    front_next      = mem_rdata;
                    res.front_value = mem_rdata;
                end
                else
                begin
                    back_next      = mem_rdata;
                    res.back_value = mem_rdata;
                end
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_item   = res;
                    state_next = deq_pkg::S_IDLE;
                end
                else
                begin
                    pend_next  = res;
                    state_next = deq_pkg::S_HOLD;
                end
            end
            deq_pkg::S_HOLD:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = deq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = deq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: design/deq_checker.sv
// Port-level assertions for the double-ended queue, bound to the top level.
module deq_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input deq_pkg::rsp_item_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result item changed while stalled");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.is_empty == (rsp.occupancy == '0))
        else $error("empty flag disagrees with occupancy");

    a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.is_empty |->
            rsp.front_value == deq_pkg::NEG_ONE && rsp.back_value == deq_pkg::NEG_ONE)
        else $error("empty queue reports end values");

    a_fail_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != deq_pkg::STATUS_OK |->
            rsp.popped_value == deq_pkg::NEG_ONE)
        else $error("failed command returned a value");

    a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.occupancy <= deq_pkg::CNT_W'(deq_pkg::CAPACITY))
        else $error("occupancy above capacity");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
